// ===== src/tsrm_pkg.sv =====
package tsrm_pkg;

   typedef enum logic [1:0] {
      MODE_TRACK    = 2'd0,
      MODE_SEARCH   = 2'd1,
      MODE_RECOVERY = 2'd2
   } mode_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_DEADZONE  = 3'd0,
      CSR_SEARCH    = 3'd1,
      CSR_FADE      = 3'd2,
      CSR_HYST      = 3'd3,
      CSR_PROBE     = 3'd4,
      CSR_GAIN_A    = 3'd5,
      CSR_GAIN_C    = 3'd6
   } csr_index_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned THRESH_W    = 15;
   localparam int unsigned FRAC_W      = 8;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned PROBE_W     = 16;
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned REQ_DATA_W  = 80;
   localparam int unsigned RSP_DATA_W  = 40;

   localparam logic [THRESH_W-1:0] DEADZONE_RESET = 15'd640;
   localparam logic [THRESH_W-1:0] SEARCH_RESET   = 15'd2048;
   localparam logic [FRAC_W-1:0]   FADE_RESET     = 8'd64;
   localparam logic [COUNT_W-1:0]  HYST_RESET     = 8'd3;
   localparam logic [PROBE_W-1:0]  PROBE_RESET    = 16'd100;
   localparam logic [SAMPLE_W-1:0] GAIN_A_RESET   = 16'd256;
   localparam logic [SAMPLE_W-1:0] GAIN_C_RESET   = 16'd256;

endpackage

// ===== src/track_search_recovery_mode_control.sv =====
// rsp_tvalid rises after the req transaction has passed the input and the result register
// throughput: one transaction per cycle; rsp_tready low stalls both stages in place
// mode, good window count and probe count advance when an item moves into the result register
// reset (synchronous, active high): mode track, counts zero, registers to their defaults,
// both pipeline stages empty
module track_search_recovery_mode_control (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tsrm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tsrm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // zscore_value, fast_average, slow_average, bandit_gain_a, bandit_gain_c
   input  logic [tsrm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // current_mode, actuate_flag, probe_pulse, chosen_gain_a, chosen_gain_c, 4 zero bits
   output logic [tsrm_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic [tsrm_pkg::THRESH_W-1:0] deadzone_ff;
   logic [tsrm_pkg::THRESH_W-1:0] search_thr_ff;
   logic [tsrm_pkg::FRAC_W-1:0]   fade_frac_ff;
   logic [tsrm_pkg::COUNT_W-1:0]  hyst_ff;
   logic [tsrm_pkg::PROBE_W-1:0]  probe_int_ff;
   logic [tsrm_pkg::SAMPLE_W-1:0] gain_a_ff;
   logic [tsrm_pkg::SAMPLE_W-1:0] gain_c_ff;

   logic                          in_valid_ff;
   logic [tsrm_pkg::REQ_DATA_W-1:0] in_data_ff;
   logic                          rsp_valid_ff;
   logic [tsrm_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [tsrm_pkg::RSP_DATA_W-1:0] rsp_data_in;

   tsrm_pkg::mode_type            mode_ff, mode_in;
   logic [tsrm_pkg::COUNT_W-1:0]  good_cnt_ff, good_cnt_in;
   logic [tsrm_pkg::PROBE_W-1:0]  probe_cnt_ff, probe_cnt_in;

   logic                          advance;
   logic signed [15:0]            z_val, fast_val, slow_val;
   logic [15:0]                   band_a, band_c;
   logic [22:0]                   fade_prod;
   logic [14:0]                   fade_thr;
   logic signed [16:0]            drop;
   logic                          faded;
   logic                          z_above_k1, z_below_k1, z_above_k2;
   logic [tsrm_pkg::COUNT_W-1:0]  good_inc;
   logic [tsrm_pkg::PROBE_W-1:0]  probe_inc;
   logic                          in_search;
   logic                          actuate;
   logic                          pulse;
   logic [15:0]                   out_a, out_c;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff   <= tsrm_pkg::DEADZONE_RESET;
         search_thr_ff <= tsrm_pkg::SEARCH_RESET;
         fade_frac_ff  <= tsrm_pkg::FADE_RESET;
         hyst_ff       <= tsrm_pkg::HYST_RESET;
         probe_int_ff  <= tsrm_pkg::PROBE_RESET;
         gain_a_ff     <= tsrm_pkg::GAIN_A_RESET;
         gain_c_ff     <= tsrm_pkg::GAIN_C_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tsrm_pkg::CSR_DEADZONE: deadzone_ff   <= csr_wdata[14:0];
            tsrm_pkg::CSR_SEARCH:   search_thr_ff <= csr_wdata[14:0];
            tsrm_pkg::CSR_FADE:     fade_frac_ff  <= csr_wdata[7:0];
            tsrm_pkg::CSR_HYST:     hyst_ff       <= csr_wdata[7:0];
            tsrm_pkg::CSR_PROBE:    probe_int_ff  <= csr_wdata;
            tsrm_pkg::CSR_GAIN_A:   gain_a_ff     <= csr_wdata;
            tsrm_pkg::CSR_GAIN_C:   gain_c_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
   end

   assign z_val    = $signed(in_data_ff[15:0]);
   assign fast_val = $signed(in_data_ff[31:16]);
   assign slow_val = $signed(in_data_ff[47:32]);
   assign band_a   = in_data_ff[63:48];
   assign band_c   = in_data_ff[79:64];

   // sudden fade: only for positive slow average, so the product is unsigned
   assign fade_prod = {8'd0, slow_val[14:0]} * {15'd0, fade_frac_ff};
   assign fade_thr  = fade_prod[22:8];
   assign drop      = {slow_val[15], slow_val} - {fast_val[15], fast_val};
   assign faded     = !slow_val[15] && (slow_val != 16'sd0)
                      && (drop > $signed({2'b00, fade_thr}));

   assign z_above_k1 = $signed({z_val[15], z_val}) > $signed({2'b00, deadzone_ff});
   assign z_below_k1 = $signed({z_val[15], z_val}) < $signed({2'b00, deadzone_ff});
   assign z_above_k2 = $signed({z_val[15], z_val}) > $signed({2'b00, search_thr_ff});
   assign good_inc   = good_cnt_ff + 8'd1;

   // next mode and good window count
   always_comb begin
      mode_in     = mode_ff;
      good_cnt_in = good_cnt_ff;
      if (faded) begin
         mode_in     = tsrm_pkg::MODE_SEARCH;
         good_cnt_in = '0;
      end else begin
         unique case (mode_ff)
            tsrm_pkg::MODE_TRACK: begin
               if (z_above_k2) begin
                  mode_in     = tsrm_pkg::MODE_SEARCH;
                  good_cnt_in = '0;
               end
            end
            tsrm_pkg::MODE_SEARCH: begin
               if (z_below_k1) begin
                  mode_in     = tsrm_pkg::MODE_RECOVERY;
                  good_cnt_in = 8'd1;
               end
            end
            tsrm_pkg::MODE_RECOVERY: begin
               if (z_below_k1) begin
                  if (good_inc >= hyst_ff) begin
                     mode_in     = tsrm_pkg::MODE_TRACK;
                     good_cnt_in = '0;
                  end else begin
                     good_cnt_in = good_inc;
                  end
               end else if (z_above_k2) begin
                  mode_in     = tsrm_pkg::MODE_SEARCH;
                  good_cnt_in = '0;
               end else begin
                  good_cnt_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // outputs from the updated mode
   always_comb begin
      in_search = (mode_in == tsrm_pkg::MODE_SEARCH);
      actuate   = in_search || z_above_k1;
      probe_inc = probe_cnt_ff + 16'd1;
      pulse     = 1'b0;
      if (in_search) begin
         probe_cnt_in = '0;
      end else if (probe_inc >= probe_int_ff) begin
         probe_cnt_in = '0;
         pulse        = 1'b1;
      end else begin
         probe_cnt_in = probe_inc;
      end
      out_a       = in_search ? gain_a_ff : band_a;
      out_c       = in_search ? gain_c_ff : band_c;
      rsp_data_in = {4'd0, out_c, out_a, pulse, actuate, mode_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= tsrm_pkg::MODE_TRACK;
         good_cnt_ff  <= '0;
         probe_cnt_ff <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         good_cnt_ff  <= good_cnt_in;
         probe_cnt_ff <= probe_cnt_in;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== verif/tsrm_mode_checker.sv =====
module tsrm_mode_checker
   import tsrm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // zscore_value, fast_average, slow_average, bandit_gain_a, bandit_gain_c
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // current_mode, actuate_flag, probe_pulse, chosen_gain_a, chosen_gain_c, 4 zero bits
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   output int                     fail_count,
   output int                     open_count
);

   typedef struct packed {
      mode_type             mode;
      logic                 actuate;
      logic                 probe;
      logic [SAMPLE_W-1:0]  gain_a;
      logic [SAMPLE_W-1:0]  gain_c;
   } decision_t;

   // shadow of the control registers
   int                  deadzone_k1;
   int                  search_k2;
   int                  fade_frac;
   logic [COUNT_W-1:0]  hyst_need;
   logic [PROBE_W-1:0]  probe_every;
   logic [SAMPLE_W-1:0] search_gain_a;
   logic [SAMPLE_W-1:0] search_gain_c;

   // shadow of the mode machine
   mode_type            mode_q;
   logic [COUNT_W-1:0]  good_windows;
   logic [PROBE_W-1:0]  probe_windows;

   decision_t expected_decisions[$];
   int        fails = 0;
   int        open_now = 0;

   assign fail_count = fails;
   assign open_count = open_now;

   task automatic report_mismatch(input string what, input logic [15:0] got_v,
                                  input logic [15:0] want_v);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got_v, want_v);
      fails++;
   endtask

   function automatic decision_t step_mode_control(input logic [REQ_DATA_W-1:0] window);
      int        z;
      int        fast;
      int        slow;
      int        thr;
      logic      faded;
      decision_t d;
      z     = $signed(window[15:0]);
      fast  = $signed(window[31:16]);
      slow  = $signed(window[47:32]);
      faded = 1'b0;

      // sudden fade overrides the thresholds, difference taken at full width
      if (slow > 0) begin
         thr = (slow * fade_frac) >>> 8;
         if (slow - fast > thr) begin
            mode_q       = MODE_SEARCH;
            good_windows = '0;
            faded        = 1'b1;
         end
      end

      if (!faded) begin
         case (mode_q)
            MODE_TRACK: begin
               if (z > search_k2) begin
                  mode_q       = MODE_SEARCH;
                  good_windows = '0;
               end
            end
            MODE_SEARCH: begin
               if (z < deadzone_k1) begin
                  mode_q       = MODE_RECOVERY;
                  good_windows = 8'd1;
               end
            end
            MODE_RECOVERY: begin
               if (z < deadzone_k1) begin
                  good_windows = good_windows + 8'd1;
                  if (good_windows >= hyst_need) begin
                     mode_q       = MODE_TRACK;
                     good_windows = '0;
                  end
               end else if (z > search_k2) begin
                  mode_q       = MODE_SEARCH;
                  good_windows = '0;
               end else begin
                  good_windows = '0;
               end
            end
            default: ;
         endcase
      end

      d.mode    = mode_q;
      d.actuate = (mode_q == MODE_SEARCH) || (z > deadzone_k1);
      d.probe   = 1'b0;
      if (mode_q == MODE_SEARCH) begin
         probe_windows = '0;
         d.gain_a      = search_gain_a;
         d.gain_c      = search_gain_c;
      end else begin
         probe_windows = probe_windows + 16'd1;
         if (probe_windows >= probe_every) begin
            probe_windows = '0;
            d.probe       = 1'b1;
         end
         d.gain_a = window[63:48];
         d.gain_c = window[79:64];
      end
      return d;
   endfunction

   always @(posedge clock) begin : watch
      decision_t want;
      if (reset) begin
         deadzone_k1   = DEADZONE_RESET;
         search_k2     = SEARCH_RESET;
         fade_frac     = FADE_RESET;
         hyst_need     = HYST_RESET;
         probe_every   = PROBE_RESET;
         search_gain_a = GAIN_A_RESET;
         search_gain_c = GAIN_C_RESET;
         mode_q        = MODE_TRACK;
         good_windows  = '0;
         probe_windows = '0;
         expected_decisions.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEADZONE: deadzone_k1   = csr_wdata[THRESH_W-1:0];
               CSR_SEARCH:   search_k2     = csr_wdata[THRESH_W-1:0];
               CSR_FADE:     fade_frac     = csr_wdata[FRAC_W-1:0];
               CSR_HYST:     hyst_need     = csr_wdata[COUNT_W-1:0];
               CSR_PROBE:    probe_every   = csr_wdata[PROBE_W-1:0];
               CSR_GAIN_A:   search_gain_a = csr_wdata;
               CSR_GAIN_C:   search_gain_c = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_decisions.push_back(step_mode_control(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_decisions.size() == 0) begin
               report_mismatch("transaction with nothing pending", rsp_tdata[15:0], '0);
            end else begin
               want = expected_decisions.pop_front();
               if (rsp_tdata[1:0] !== want.mode)
                  report_mismatch("current_mode", rsp_tdata[1:0], want.mode);
               if (rsp_tdata[2] !== want.actuate)
                  report_mismatch("actuate_flag", rsp_tdata[2], want.actuate);
               if (rsp_tdata[3] !== want.probe)
                  report_mismatch("probe_pulse", rsp_tdata[3], want.probe);
               if (rsp_tdata[19:4] !== want.gain_a)
                  report_mismatch("chosen_gain_a", rsp_tdata[19:4], want.gain_a);
               if (rsp_tdata[35:20] !== want.gain_c)
                  report_mismatch("chosen_gain_c", rsp_tdata[35:20], want.gain_c);
               if (rsp_tdata[39:36] !== 4'b0)
                  report_mismatch("padding", rsp_tdata[39:36], '0);
            end
         end
      end
      open_now = expected_decisions.size();
   end

endmodule

// ===== verif/track_search_recovery_mode_control_tb.sv =====
module track_search_recovery_mode_control_tb;
   import tsrm_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int QUIET_LIMIT       = 5000;
   localparam int WINDOWS_PER_PHASE = 105;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   // zscore_value, fast_average, slow_average, bandit_gain_a, bandit_gain_c
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // current_mode, actuate_flag, probe_pulse, chosen_gain_a, chosen_gain_c, 4 zero bits
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   int fail_count;
   int open_count;
   int idle_pct;
   int stall_pct;
   int quiet_cycles = 0;

   // settings currently loaded, used to aim the z-scores and fades
   int zone_lo = 640;
   int zone_hi = 2048;
   int fade_now = 64;

   track_search_recovery_mode_control u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tsrm_mode_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("track_search_recovery_mode_control verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [15:0] sat16(input int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return 16'(v);
   endfunction

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_window(input logic [REQ_DATA_W-1:0] window);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= window;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_fields(input int z, input int fast, input int slow,
                              input int gain_a, input int gain_c);
      send_window({sat16(gain_c), sat16(gain_a), sat16(slow), sat16(fast), sat16(z)});
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (open_count != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [15:0] k1, input logic [15:0] k2,
                                input logic [15:0] frac, input logic [15:0] hyst,
                                input logic [15:0] interval, input logic [15:0] gain_a,
                                input logic [15:0] gain_c);
      write_reg(CSR_DEADZONE, k1);
      write_reg(CSR_SEARCH, k2);
      write_reg(CSR_FADE, frac);
      write_reg(CSR_HYST, hyst);
      write_reg(CSR_PROBE, interval);
      write_reg(CSR_GAIN_A, gain_a);
      write_reg(CSR_GAIN_C, gain_c);
      csr_we   <= 1'b0;
      zone_lo  = k1[THRESH_W-1:0];
      zone_hi  = k2[THRESH_W-1:0];
      fade_now = frac[FRAC_W-1:0];
   endtask

   function automatic logic [REQ_DATA_W-1:0] random_window();
      int z;
      int slow;
      int fast;
      int pick;
      pick = $urandom_range(99);
      if (pick < 35)
         z = zone_lo - 1 - $urandom_range(255);
      else if (pick < 50)
         z = (zone_hi >= zone_lo) ? zone_lo + $urandom_range(zone_hi - zone_lo) : zone_lo;
      else if (pick < 65)
         z = zone_hi - 1 + $urandom_range(300);
      else if (pick < 72)
         z = zone_lo - 1 + $urandom_range(2);
      else
         z = $signed(16'($urandom));

      pick = $urandom_range(99);
      if (pick < 12) begin
         // straddle the fade threshold
         slow = $urandom_range(32767, 1);
         fast = slow - ((slow * fade_now) >>> 8) - 1 + $urandom_range(2);
      end else if (pick < 22) begin
         slow = $signed(16'($urandom));
         fast = $signed(16'($urandom));
      end else begin
         slow = $signed(16'($urandom));
         fast = slow + $urandom_range(200);
      end
      return {16'($urandom), 16'($urandom), sat16(slow), sat16(fast), sat16(z)};
   endfunction

   // mode 0 free flow, 1 sender gaps, 2 receiver stalls, 3 both
   task automatic run_phase(input int count, input int flow_mode);
      case (flow_mode)
         1:       begin idle_pct = 50; stall_pct = 0;  end
         2:       begin idle_pct = 0;  stall_pct = 50; end
         3:       begin idle_pct = 26; stall_pct = 26; end
         default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_drained();
         send_window(random_window());
      end
      wait_drained();
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int k1;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_DEADZONE;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b1;
      idle_pct   = 0;
      stall_pct  = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk through the mode machine under reset settings
      send_fields(0, 0, 0, -32768, 32767);
      send_fields(32767, 0, 0, 32767, -32768);
      send_fields(-32768, 0, 0, 1, 2);
      send_fields(640, 0, 0, 3, 4);
      send_fields(641, 0, 0, 5, 6);
      send_fields(0, 0, 0, 7, 8);
      send_fields(0, 0, 0, 9, 10);
      send_fields(0, 0, 0, 11, 12);
      send_fields(2048, 0, 0, 13, 14);
      send_fields(2049, 0, 0, 15, 16);
      wait_drained();
      repeat (4) @(negedge clock);
      // out-of-range index must not disturb any register
      write_reg(CSR_UNUSED, 16'h0000);
      csr_we <= 1'b0;
      @(negedge clock);
      send_fields(-1, 0, 0, 17, 18);
      send_fields(1, 24576, 32767, 19, 20);
      send_fields(0, 24575, 32767, 21, 22);
      send_fields(-100, -32768, 0, 23, 24);
      send_fields(0, 32767, -32768, 25, 26);
      send_fields(0, -32768, 1, 27, 28);
      send_fields(-5, 0, 0, 29, 30);
      send_fields(2049, 0, 0, 31, 32);
      send_fields(-5, 0, 0, 33, 34);
      send_fields(0, 0, 0, 35, 36);
      send_fields(0, 0, 0, 37, 38);
      send_fields(1000, 0, 0, -32768, 32767);
      wait_drained();
      repeat (4) @(negedge clock);

      load_settings(16'd300, 16'd1500, 16'd128, 16'd2, 16'd5, 16'hFE00, 16'h0400);
      run_phase(WINDOWS_PER_PHASE, 0);
      // upper extremes, thresholds written wider than the register
      load_settings(16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'hFFFF, 16'h7FFF, 16'h8000);
      run_phase(WINDOWS_PER_PHASE, 1);
      // lower extremes: hysteresis 0 returns at once, interval 0 probes outside search
      load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 16'hFFFF);
      run_phase(WINDOWS_PER_PHASE, 2);
      load_settings(16'd200, 16'd3000, 16'd32, 16'd1, 16'd1, 16'($urandom), 16'($urandom));
      run_phase(WINDOWS_PER_PHASE, 3);

      for (int j = 0; j < 4; j++) begin
         k1 = $urandom_range(3000);
         load_settings(16'(k1),
                       ($urandom_range(99) < 80) ? 16'(k1 + $urandom_range(3000))
                                                 : 16'($urandom_range(3000)),
                       16'($urandom_range(255)), 16'($urandom_range(6, 1)),
                       16'($urandom_range(12, 1)), 16'($urandom), 16'($urandom));
         run_phase(WINDOWS_PER_PHASE, j);
      end

      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("track_search_recovery_mode_control verification clean");
      else
         $display("track_search_recovery_mode_control verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/tsrm_pkg.sv
src/track_search_recovery_mode_control.sv
verif/tsrm_mode_checker.sv
verif/track_search_recovery_mode_control_tb.sv
